### hdl/assert_macros.svh
// Assertion helper macros shared by the Fermat trial RTL.
// Depends on clk_i and rst_ni existing in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked check, quiet while reset is applied
`define FPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Clocked check that also runs through reset
`define FPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define FPT_ASSERT(lbl, prop, msg)
`define FPT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hdl/fpt_pkg.sv
// Package for the Fermat primality trial: widths, register map, FSM and
// datapath command types. No dependencies.
`timescale 1ns / 1ps

package fpt_pkg;

  // Field and bus widths
  localparam int unsigned WORD_W           = 31;
  localparam int unsigned WORD_IDX_W       = $clog2(WORD_W);
  localparam int unsigned MODULUS_BITS_DEF = 31;
  localparam int unsigned APB_DATA_W       = 32;
  localparam int unsigned APB_ADDR_W       = 2;

  // Register map
  localparam logic [APB_ADDR_W-1:0] ADDR_MODULUS = 2'd0;
  localparam logic [WORD_W-1:0]     MODULUS_RST  = 31'd5;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_BASE,
    S_SCAN,
    S_SQ_INIT,
    S_SQ_RUN,
    S_SQ_CHK,
    S_MUL_INIT,
    S_MUL_RUN,
    S_TAKE,
    S_NEXT,
    S_DONE
  } fpt_state_e;

  // Datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_BASE,
    DP_IDX_DEC,
    DP_SQ_INIT,
    DP_MUL_INIT,
    DP_MUL_STEP,
    DP_TAKE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic small_mod;   // modulus below four
    logic cnt_zero;    // serial step counter at its last bit
    logic e_bit;       // exponent bit at the current index
    logic idx_zero;    // exponent index at bit zero
    logic sqrt_hit;    // square is one from a value other than 1 or m-1
    logic x_is_one;    // running power equals one
  } dp_stat_t;

  typedef struct packed {
    logic load;
    logic prime;
  } res_cmd_t;

endpackage

### hdl/fpt_if.sv
// Valid/ready stream interfaces for the Fermat trial request and result.
// Depends on fpt_pkg for the word width.
`timescale 1ns / 1ps

interface fpt_in_if import fpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

interface fpt_out_if;
  logic valid;
  logic ready;
  logic probably_prime;

  modport source (output valid, output probably_prime, input ready);
  modport sink   (input valid, input probably_prime, output ready);
endinterface

### hdl/fpt_datapath.sv
// Datapath of the Fermat trial: serial remainder unit for the base and a
// bit-serial modular multiplier, plus exponent bit tracking. Uses fpt_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fpt_datapath import fpt_pkg::*; #(
  parameter int unsigned MODULUS_BITS = MODULUS_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  input  logic [WORD_W-1:0] modulus_i,
  input  logic [WORD_W-1:0] random_word_i,
  output dp_stat_t          stat_o
);

  localparam int unsigned MW    = MODULUS_BITS;
  localparam int unsigned IDX_W = $clog2(MW);
  localparam int unsigned CNT_W = (IDX_W > WORD_IDX_W) ? IDX_W : WORD_IDX_W;

  logic [MW-1:0]     m_cur;
  logic [MW-1:0]     m_q, e_q, d_q, a_q, x_q, mc_q, mp_q, acc_q;
  logic [WORD_W-1:0] rw_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [IDX_W-1:0]  idx_q;

  logic [MW:0]       div_t;
  logic [MW+1:0]     div_diff;
  logic [MW-1:0]     div_next;
  logic              mul_bit;
  logic [MW+1:0]     mul_s;
  logic [MW+2:0]     mul_sub1, mul_sub2;
  logic [MW-1:0]     mul_next;

  assign m_cur = MW'(modulus_i);

  // Restoring remainder step: shift in one bit of the word, subtract if it fits
  assign div_t    = {acc_q, rw_q[cnt_q[WORD_IDX_W-1:0]]};
  assign div_diff = {1'b0, div_t} - {2'b00, d_q};
  assign div_next = div_diff[MW+1] ? div_t[MW-1:0] : div_diff[MW-1:0];

  // Modular multiply step: acc = (2*acc + bit*mc) mod m, sum stays below 3m
  assign mul_bit  = mp_q[cnt_q[IDX_W-1:0]];
  assign mul_s    = {1'b0, acc_q, 1'b0} + {2'b00, (mul_bit ? mc_q : '0)};
  assign mul_sub1 = {1'b0, mul_s} - {3'b000, m_q};
  assign mul_sub2 = {1'b0, mul_s} - {2'b00, m_q, 1'b0};

  always_comb begin
    if (!mul_sub2[MW+2]) begin
      mul_next = mul_sub2[MW-1:0];
    end else if (!mul_sub1[MW+2]) begin
      mul_next = mul_sub1[MW-1:0];
    end else begin
      mul_next = mul_s[MW-1:0];
    end
  end

  // Counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      case (cmd_i.op)
        DP_DIV_INIT: cnt_q <= CNT_W'(WORD_W - 1);
        DP_DIV_STEP, DP_MUL_STEP: cnt_q <= cnt_q - 1'b1;
        DP_SQ_INIT, DP_MUL_INIT: cnt_q <= CNT_W'(MW - 1);
        DP_BASE:     idx_q <= IDX_W'(MW - 1);
        DP_IDX_DEC:  idx_q <= idx_q - 1'b1;
        default: ;
      endcase
    end
  end

  // Operand and accumulator registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_DIV_INIT: begin
        rw_q  <= random_word_i;
        m_q   <= m_cur;
        e_q   <= m_cur - MW'(1);
        d_q   <= m_cur - MW'(3);
        acc_q <= '0;
      end
      DP_DIV_STEP: acc_q <= div_next;
      DP_BASE: begin
        a_q <= acc_q + MW'(2);
        x_q <= acc_q + MW'(2);
      end
      DP_SQ_INIT: begin
        acc_q <= '0;
        mc_q  <= x_q;
        mp_q  <= x_q;
      end
      DP_MUL_INIT: begin
        acc_q <= '0;
        mc_q  <= x_q;
        mp_q  <= a_q;
      end
      DP_MUL_STEP: acc_q <= mul_next;
      DP_TAKE:     x_q   <= acc_q;
      default: ;
    endcase
  end

  // Status back to the controller
  always_comb begin
    stat_o.small_mod = (m_cur[MW-1:2] == '0);
    stat_o.cnt_zero  = (cnt_q == '0);
    stat_o.e_bit     = e_q[idx_q];
    stat_o.idx_zero  = (idx_q == '0);
    stat_o.sqrt_hit  = (acc_q == MW'(1)) && (x_q != MW'(1)) && (x_q != e_q);
    stat_o.x_is_one  = (x_q == MW'(1));
  end

  `FPT_ASSERT(a_rem_below_divisor, (cmd_i.op == DP_DIV_STEP) |=> (acc_q < d_q), "remainder not below divisor")
  `FPT_ASSERT(a_base_in_range, (cmd_i.op == DP_BASE) |=> (a_q >= MW'(2) && a_q < e_q), "base outside [2, m-2]")
  `FPT_ASSERT(a_product_reduced, (cmd_i.op == DP_MUL_STEP) |=> (acc_q < m_q), "product not reduced below modulus")

endmodule

### hdl/fpt_ctrl.sv
// Controller FSM for the Fermat trial: sequences remainder, exponent scan,
// square and multiply passes, and the verdict. Uses fpt_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fpt_ctrl import fpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_free_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output res_cmd_t res_o
);

  fpt_state_e state_q, state_d;
  logic       verdict_q, verdict_d;

  // State and verdict registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      verdict_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      verdict_q <= verdict_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d     = state_q;
    verdict_d   = verdict_q;
    cmd_o.op    = DP_NOP;
    in_ready_o  = 1'b0;
    res_o.load  = 1'b0;
    res_o.prime = verdict_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (stat_i.small_mod) begin
            verdict_d = 1'b0;
            state_d   = S_DONE;
          end else begin
            cmd_o.op = DP_DIV_INIT;
            state_d  = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd_o.op = DP_DIV_STEP;
        if (stat_i.cnt_zero) state_d = S_BASE;
      end
      S_BASE: begin
        cmd_o.op = DP_BASE;
        state_d  = S_SCAN;
      end
      // walk down to the top set bit of m-1, then start one below it
      S_SCAN: begin
        cmd_o.op = DP_IDX_DEC;
        if (stat_i.e_bit) state_d = S_SQ_INIT;
      end
      S_SQ_INIT: begin
        cmd_o.op = DP_SQ_INIT;
        state_d  = S_SQ_RUN;
      end
      S_SQ_RUN: begin
        cmd_o.op = DP_MUL_STEP;
        if (stat_i.cnt_zero) state_d = S_SQ_CHK;
      end
      S_SQ_CHK: begin
        if (stat_i.sqrt_hit) begin
          verdict_d = 1'b0;
          state_d   = S_DONE;
        end else begin
          cmd_o.op = DP_TAKE;
          state_d  = stat_i.e_bit ? S_MUL_INIT : S_NEXT;
        end
      end
      S_MUL_INIT: begin
        cmd_o.op = DP_MUL_INIT;
        state_d  = S_MUL_RUN;
      end
      S_MUL_RUN: begin
        cmd_o.op = DP_MUL_STEP;
        if (stat_i.cnt_zero) state_d = S_TAKE;
      end
      S_TAKE: begin
        cmd_o.op = DP_TAKE;
        state_d  = S_NEXT;
      end
      S_NEXT: begin
        if (stat_i.idx_zero) begin
          verdict_d = stat_i.x_is_one;
          state_d   = S_DONE;
        end else begin
          cmd_o.op = DP_IDX_DEC;
          state_d  = S_SQ_INIT;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          res_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `FPT_ASSERT(a_accept_leaves_idle, (state_q == S_IDLE && in_valid_i) |=> (state_q != S_IDLE), "request accepted but controller stayed idle")
  `FPT_ASSERT(a_done_drains, (state_q == S_DONE && out_free_i) |=> (state_q == S_IDLE), "result slot free but verdict not issued")
  `FPT_ASSERT(a_sqrt_composite, (state_q == S_SQ_CHK && stat_i.sqrt_hit) |=> (state_q == S_DONE && !verdict_q), "nontrivial root of one not reported composite")

endmodule

### hdl/fermat_primality_test_top.sv
// Fermat primality trial, top level: APB modulus register, output register,
// controller and datapath. Depends on fpt_pkg, fpt_if, fpt_ctrl, fpt_datapath.
`timescale 1ns / 1ps

// One request carries a random word; the block picks the base
// word mod (modulus-3) + 2 and raises it to modulus-1 modulo modulus by
// square-and-multiply, answering one probably_prime bit per request. Requests
// are handled one at a time. A request first reduces the word to the base and
// scans down to the top set bit of modulus-1; then, for every exponent bit
// below the top, it runs a squaring, followed by a multiply when that bit is
// one. The squaring and the multiply use the bit-serial modular multiplier,
// which retires one multiplier bit per cycle. A modulus below four answers 0
// without a trial, and a squaring that finds a nontrivial root of one ends the
// trial early. A new request is taken while the previous verdict still waits
// in the output register. The modulus is written over APB at offset 0 and
// must only change while no request is in flight.
module fermat_primality_test_top import fpt_pkg::*; #(
  parameter int unsigned MODULUS_BITS = MODULUS_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fpt_in_if.sink                rnd_i,
  fpt_out_if.source             res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [WORD_W-1:0] modulus_q;
  logic              out_valid_q;
  logic              out_prime_q;
  logic              out_free;
  dp_cmd_t           cmd;
  dp_stat_t          stat;
  res_cmd_t          res_cmd;

  // APB modulus register
  assign pready = 1'b1;
  assign prdata = {{(APB_DATA_W - WORD_W){1'b0}}, modulus_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RST;
    end else if (psel && penable && pwrite && (paddr == ADDR_MODULUS)) begin
      modulus_q <= pwdata[WORD_W-1:0];
    end
  end

  // Output register
  assign out_free = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_cmd.load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_cmd.load) out_prime_q <= res_cmd.prime;
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.probably_prime = out_prime_q;

  // Controller
  fpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rnd_i.valid),
    .in_ready_o (rnd_i.ready),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .res_o      (res_cmd)
  );

  // Datapath
  fpt_datapath #(
    .MODULUS_BITS (MODULUS_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .modulus_i     (modulus_q),
    .random_word_i (rnd_i.random_word),
    .stat_o        (stat)
  );

endmodule
